### sv/mail_quoted_string_escaper_macros.svh
// assertion macros of the escaper rtl
// no dependencies; included by mqse_ctrl, which carries concurrent checks
`ifndef MAIL_QUOTED_STRING_ESCAPER_MACROS_SVH
`define MAIL_QUOTED_STRING_ESCAPER_MACROS_SVH

`ifndef SYNTHESIS
`define MQSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqse assertion failed");
`define MQSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqse assertion failed");
`else
`define MQSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MQSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/mqse_pkg.sv
// types, constants and character class functions of the quoted string escaper
// no dependencies; used by the interfaces, controller, datapath and top level
package mqse_pkg;

    localparam int DEF_MAX_LEN     = 256;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int OUT_LEN_W  = 10;
    localparam int OUT_CNT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_QUOT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_HI  = 2'd3;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [1:0] OUT_TEXT      = 2'd0;
    localparam logic [1:0] OUT_SUM       = 2'd1;
    localparam logic [1:0] OUT_SUM_TRUNC = 2'd2;
    localparam logic [1:0] OUT_NONE      = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_US     = 8'h1f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    localparam int CNT_CR    = 0;
    localparam int CNT_NL    = 1;
    localparam int CNT_NUL   = 2;
    localparam int CNT_CTL   = 3;
    localparam int CNT_EXT   = 4;
    localparam int CNT_OTHER = 5;
    localparam int CNT_TOTAL = 6;
    localparam int NUM_CNT   = 7;

    typedef struct packed {
        logic take;
        logic esc2;
        logic rd;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic to_esc2;
        logic to_read;
        logic res_now;
        logic esc_last;
    } t_stat;

    function automatic logic is_internal(logic [7:0] b, logic [127:0] imask);
        logic r;
        r = 1'b0;
        if (b != CH_NUL && !b[7]) begin
            if (b == CH_DQUOTE || b == CH_BSLASH || b == CH_CR || b == CH_LF) begin
                r = 1'b1;
            end else begin
                r = imask[b[6:0]];
            end
        end
        return r;
    endfunction

    function automatic logic is_quotable(logic [7:0] b, logic [127:0] imask,
                                         logic [127:0] qmask);
        logic r;
        r = 1'b0;
        if (!b[7]) begin
            r = (b <= CH_US) || (b == CH_DEL) || (b == CH_SPACE)
                || is_internal(b, imask) || qmask[b[6:0]];
        end
        return r;
    endfunction

endpackage

### sv/mqse_if.sv
// handshake channels of the quoted string escaper: input, result and register write
// depends on mqse_pkg for field widths
interface mqse_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, kind, in_byte, in_last, input ready);
    modport sink (input valid, kind, in_byte, in_last, output ready);
endinterface

interface mqse_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     out_kind;
    logic [7:0]                     out_byte;
    logic                           out_last;
    logic                           quoted;
    logic [mqse_pkg::OUT_LEN_W-1:0] out_length;
    logic [mqse_pkg::OUT_CNT_W-1:0] cr_count;
    logic [mqse_pkg::OUT_CNT_W-1:0] nl_count;
    logic [mqse_pkg::OUT_CNT_W-1:0] nul_count;
    logic [mqse_pkg::OUT_CNT_W-1:0] ctl_count;
    logic [mqse_pkg::OUT_CNT_W-1:0] ext_count;
    logic [mqse_pkg::OUT_CNT_W-1:0] other_count;
    logic [mqse_pkg::OUT_CNT_W-1:0] total_count;

    modport source (output valid, out_kind, out_byte, out_last, quoted, out_length,
                    cr_count, nl_count, nul_count, ctl_count, ext_count, other_count,
                    total_count, input ready);
    modport sink (input valid, out_kind, out_byte, out_last, quoted, out_length,
                  cr_count, nl_count, nul_count, ctl_count, ext_count, other_count,
                  total_count, output ready);
endinterface

interface mqse_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mqse_pkg::CFG_IDX_W-1:0]  index;
    logic [mqse_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/mail_quoted_string_escaper.sv
// top level of the quoted string escaper: channel wiring around controller and datapath
// depends on mqse_pkg, the channel interfaces, mqse_ctrl and mqse_dp
//
// Usage:
// i_in carries items: kind 0 is a text byte of a string (in_last marks its end),
// kind 1 asks for the next byte of the quoted, escaped text. o_out carries results.
// i_cfg writes the four 64-bit character masks (index 0..3) and is always ready;
// write it only while the block is idle.
// A text byte without in_last gives no result; with in_last it gives the summary.
// Each drain item gives one result: a text byte, or out_kind 3 when none is pending.
// An escaped text byte that is stored passes through the S_ESC2 state to write its
// second byte (the escape buffer has one write port); a dropped byte does not. A drain
// item whose byte comes from the buffer passes through S_READ (registered memory read);
// a quote or nothing pending is answered from the idle state.
// A result sits in an output register; a new item is taken only while the controller
// is idle and that register is taken or empty, so a stalled receiver holds off the input.
// Reset (i_rst_n low, synchronous) clears masks, pointers, flags and counters;
// the buffer itself is not cleared and needs no clearing pass.
module mail_quoted_string_escaper #(
    parameter int MAX_LEN     = mqse_pkg::DEF_MAX_LEN,
    parameter int COUNT_WIDTH = mqse_pkg::DEF_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqse_in_if.sink    i_in,
    mqse_out_if.source o_out,
    mqse_cfg_if.sink   i_cfg
);

    mqse_pkg::t_cmd                 cmd;
    mqse_pkg::t_stat                stat;
    logic [mqse_pkg::OUT_CNT_W-1:0] count [mqse_pkg::NUM_CNT];

    assign i_cfg.ready = 1'b1;

    mqse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mqse_dp #(
        .MAX_LEN     (MAX_LEN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_kind      (i_in.kind),
        .i_byte      (i_in.in_byte),
        .i_last      (i_in.in_last),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_kind      (o_out.out_kind),
        .o_byte      (o_out.out_byte),
        .o_last      (o_out.out_last),
        .o_quoted    (o_out.quoted),
        .o_length    (o_out.out_length),
        .o_count     (count)
    );

    assign o_out.cr_count    = count[mqse_pkg::CNT_CR];
    assign o_out.nl_count    = count[mqse_pkg::CNT_NL];
    assign o_out.nul_count   = count[mqse_pkg::CNT_NUL];
    assign o_out.ctl_count   = count[mqse_pkg::CNT_CTL];
    assign o_out.ext_count   = count[mqse_pkg::CNT_EXT];
    assign o_out.other_count = count[mqse_pkg::CNT_OTHER];
    assign o_out.total_count = count[mqse_pkg::CNT_TOTAL];

endmodule

### sv/mqse_ctrl.sv
// controller state machine of the quoted string escaper: handshakes and sequencing
// depends on mqse_pkg (command and status structs) and the assertion macro header
`include "mail_quoted_string_escaper_macros.svh"

module mqse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mqse_pkg::t_stat i_stat,
    output mqse_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ESC2 = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       take;
    logic       load;

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    load = i_stat.res_now;
                    if (i_stat.to_esc2) begin
                        n_state = S_ESC2;
                    end else if (i_stat.to_read) begin
                        n_state = S_READ;
                    end
                end
            end
            S_ESC2: begin
                load    = i_stat.esc_last;
                n_state = S_IDLE;
            end
            S_READ: begin
                load    = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid && !i_out_ready;
        if (load) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_cmd.take  = take;
    assign o_cmd.esc2  = (r_state == S_ESC2);
    assign o_cmd.rd    = (r_state == S_READ);
    assign o_cmd.load  = load;

    `MQSE_ASSERT_NEXT(a_esc2_one_cycle, i_clk, i_rst_n, r_state == S_ESC2, r_state == S_IDLE)
    `MQSE_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, load, !r_ovalid || i_out_ready)
    `MQSE_ASSERT_NEXT(a_read_gives_result, i_clk, i_rst_n, r_state == S_READ, r_ovalid)

endmodule

### sv/mqse_dp.sv
// datapath of the quoted string escaper: masks, escape buffer, pointers, counters
// and result register; depends on mqse_pkg and is sequenced by mqse_ctrl
module mqse_dp #(
    parameter int MAX_LEN     = mqse_pkg::DEF_MAX_LEN,
    parameter int COUNT_WIDTH = mqse_pkg::DEF_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mqse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mqse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_kind,
    input  logic [7:0]                      i_byte,
    input  logic                            i_last,
    input  mqse_pkg::t_cmd                  i_cmd,
    output mqse_pkg::t_stat                 o_stat,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_byte,
    output logic                            o_last,
    output logic                            o_quoted,
    output logic [mqse_pkg::OUT_LEN_W-1:0]  o_length,
    output logic [mqse_pkg::OUT_CNT_W-1:0]  o_count [mqse_pkg::NUM_CNT]
);

    localparam int DEPTH  = 2 * MAX_LEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 3);
    localparam int LEN_XW = (PTR_W > mqse_pkg::OUT_LEN_W) ? PTR_W : mqse_pkg::OUT_LEN_W;
    localparam int CNT_XW = (COUNT_WIDTH > mqse_pkg::OUT_CNT_W) ? COUNT_WIDTH
                                                                : mqse_pkg::OUT_CNT_W;
    localparam int NC     = mqse_pkg::NUM_CNT;

    logic [127:0]             r_qmask;
    logic [127:0]             r_imask;
    logic [7:0]               r_mem [DEPTH];
    logic [7:0]               r_rd_data;
    logic                     r_rd_last;
    logic [7:0]               r_pend_byte;
    logic                     r_pend_last;
    logic [PTR_W-1:0]         r_wp;
    logic [PTR_W-1:0]         n_wp;
    logic [PTR_W-1:0]         r_rp;
    logic [PTR_W-1:0]         n_rp;
    logic                     r_q;
    logic                     n_q;
    logic                     r_tr;
    logic                     n_tr;
    logic                     r_open;
    logic                     n_open;
    logic [COUNT_WIDTH-1:0]   r_cnt [NC];
    logic [COUNT_WIDTH-1:0]   n_cnt [NC];
    logic [CNT_XW-1:0]        cnt_x [NC];
    logic [NC-1:0]            cls;

    logic                     take_text;
    logic                     take_drain;
    logic [PTR_W-1:0]         wp_cur;
    logic                     q_cur;
    logic                     tr_cur;
    logic                     esc;
    logic                     fit;
    logic [PTR_W-1:0]         len;
    logic [PTR_W-1:0]         n_len;
    logic [LEN_XW-1:0]        n_len_x;
    logic                     drain_none;
    logic                     drain_edge;
    logic                     drain_ram;
    logic                     drain_tail;
    logic                     mem_we;
    logic [AW-1:0]            wr_addr;
    logic [7:0]               wr_data;
    logic [AW-1:0]            rd_addr;

    assign take_text  = i_cmd.take && (i_kind == mqse_pkg::KIND_TEXT);
    assign take_drain = i_cmd.take && (i_kind == mqse_pkg::KIND_DRAIN);

    // a text byte with no open string starts a fresh one
    assign wp_cur = r_open ? r_wp : '0;
    assign q_cur  = r_open && r_q;
    assign tr_cur = r_open && r_tr;

    assign esc = mqse_pkg::is_internal(i_byte, r_imask);
    assign fit = (wp_cur + (esc ? PTR_W'(2) : PTR_W'(1))) <= PTR_W'(DEPTH);

    assign len        = r_wp + (r_q ? PTR_W'(2) : PTR_W'(0));
    assign drain_none = r_open || (r_rp >= len);
    assign drain_tail = (r_rp == len - PTR_W'(1));
    assign drain_edge = r_q && ((r_rp == '0) || drain_tail);
    assign drain_ram  = !drain_none && !drain_edge;
    assign rd_addr    = r_q ? AW'(r_rp - PTR_W'(1)) : AW'(r_rp);

    assign o_stat.to_esc2  = (i_kind == mqse_pkg::KIND_TEXT) && esc && fit;
    assign o_stat.to_read  = (i_kind == mqse_pkg::KIND_DRAIN) && drain_ram;
    assign o_stat.res_now  = (i_kind == mqse_pkg::KIND_TEXT) ? (i_last && !(esc && fit))
                                                             : !drain_ram;
    assign o_stat.esc_last = r_pend_last;

    always_comb begin
        cls = '0;
        if (i_byte == mqse_pkg::CH_CR) begin
            cls[mqse_pkg::CNT_CR] = 1'b1;
        end else if (i_byte == mqse_pkg::CH_LF) begin
            cls[mqse_pkg::CNT_NL] = 1'b1;
        end else if (i_byte == mqse_pkg::CH_NUL) begin
            cls[mqse_pkg::CNT_NUL] = 1'b1;
        end else if (i_byte <= mqse_pkg::CH_US || i_byte == mqse_pkg::CH_DEL) begin
            cls[mqse_pkg::CNT_CTL] = 1'b1;
        end else if (i_byte[7]) begin
            cls[mqse_pkg::CNT_EXT] = 1'b1;
        end else begin
            cls[mqse_pkg::CNT_OTHER] = 1'b1;
        end
        cls[mqse_pkg::CNT_TOTAL] = 1'b1;
    end

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_cnt[i] = r_cnt[i];
            if (take_text && cls[i] && (r_cnt[i] != '1)) begin
                n_cnt[i] = r_cnt[i] + COUNT_WIDTH'(1);
            end
        end
    end

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_q     = r_q;
        n_tr    = r_tr;
        n_open  = r_open;
        mem_we  = 1'b0;
        wr_addr = AW'(wp_cur);
        wr_data = i_byte;
        if (take_text) begin
            n_open = !i_last;
            n_q    = q_cur;
            n_tr   = tr_cur;
            n_wp   = wp_cur;
            if (!r_open) begin
                n_rp = '0;
            end
            if (fit) begin
                mem_we = 1'b1;
                n_wp   = wp_cur + PTR_W'(1);
                if (esc) begin
                    wr_data = mqse_pkg::CH_BSLASH;
                end
                if (mqse_pkg::is_quotable(i_byte, r_imask, r_qmask)) begin
                    n_q = 1'b1;
                end
            end else begin
                n_tr = 1'b1;
            end
        end else if (i_cmd.esc2) begin
            mem_we  = 1'b1;
            wr_addr = AW'(r_wp);
            wr_data = r_pend_byte;
            n_wp    = r_wp + PTR_W'(1);
        end else if (take_drain && !drain_none) begin
            n_rp = r_rp + PTR_W'(1);
        end
    end

    assign n_len   = n_wp + (n_q ? PTR_W'(2) : PTR_W'(0));
    assign n_len_x = LEN_XW'(n_len);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmask <= '0;
            r_imask <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_q     <= 1'b0;
            r_tr    <= 1'b0;
            r_open  <= 1'b0;
            for (int i = 0; i < NC; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mqse_pkg::CFG_QUOT_LO: r_qmask[63:0]   <= i_cfg_data;
                    mqse_pkg::CFG_QUOT_HI: r_qmask[127:64] <= i_cfg_data;
                    mqse_pkg::CFG_INT_LO:  r_imask[63:0]   <= i_cfg_data;
                    mqse_pkg::CFG_INT_HI:  r_imask[127:64] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_q    <= n_q;
            r_tr   <= n_tr;
            r_open <= n_open;
            for (int i = 0; i < NC; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // pending escaped byte and drain tail flag
    always_ff @(posedge i_clk) begin
        if (take_text) begin
            r_pend_byte <= i_byte;
            r_pend_last <= i_last;
        end
        if (take_drain) begin
            r_rd_last <= drain_tail;
        end
    end

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            cnt_x[i] = CNT_XW'(n_cnt[i]);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_quoted <= n_q;
            o_length <= n_len_x[mqse_pkg::OUT_LEN_W-1:0];
            for (int i = 0; i < NC; i++) begin
                o_count[i] <= cnt_x[i][mqse_pkg::OUT_CNT_W-1:0];
            end
            if (i_cmd.rd) begin
                o_kind <= mqse_pkg::OUT_TEXT;
                o_byte <= r_rd_data;
                o_last <= r_rd_last;
            end else if (i_cmd.esc2 || take_text) begin
                o_kind <= n_tr ? mqse_pkg::OUT_SUM_TRUNC : mqse_pkg::OUT_SUM;
                o_byte <= '0;
                o_last <= 1'b0;
            end else if (drain_none) begin
                o_kind <= mqse_pkg::OUT_NONE;
                o_byte <= '0;
                o_last <= 1'b0;
            end else begin
                o_kind <= mqse_pkg::OUT_TEXT;
                o_byte <= mqse_pkg::CH_DQUOTE;
                o_last <= drain_tail;
            end
        end
    end

endmodule

### dv/tb.sv
// self-checking bench for the quoted string escaper: text, drain and register write traffic
// depends on mqse_pkg, the channel interfaces and mail_quoted_string_escaper
// an in-bench predictor tracks buffer, quoting and class counters per accepted transfer
`timescale 1ns / 1ps

module tb;

    localparam int BUF_DEPTH     = 2 * mqse_pkg::DEF_MAX_LEN;
    localparam int PHASE_ITEMS   = 140;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 10;
    localparam int IDLE_LIMIT    = 2000;

    localparam logic [7:0] DIR_BYTES [10] = '{
        mqse_pkg::CH_NUL, mqse_pkg::CH_US, mqse_pkg::CH_DEL, mqse_pkg::CH_SPACE,
        mqse_pkg::CH_DQUOTE, mqse_pkg::CH_BSLASH, mqse_pkg::CH_CR, mqse_pkg::CH_LF,
        8'h80, 8'hff};
    localparam logic [7:0] SPECIALS [10] = '{
        mqse_pkg::CH_NUL, mqse_pkg::CH_US, mqse_pkg::CH_SPACE, mqse_pkg::CH_DQUOTE,
        mqse_pkg::CH_BSLASH, mqse_pkg::CH_CR, mqse_pkg::CH_LF, mqse_pkg::CH_DEL,
        8'h80, 8'hff};

    typedef struct packed {
        logic [1:0]                                            kind;
        logic [7:0]                                            data;
        logic                                                  last;
        logic                                                  quoted;
        logic [mqse_pkg::OUT_LEN_W-1:0]                        length;
        logic [mqse_pkg::NUM_CNT-1:0][mqse_pkg::OUT_CNT_W-1:0] cnt;
    } t_esc_result;

    class t_escaper_scoreboard;
        logic [127:0]                 quot_set;
        logic [127:0]                 esc_set;
        logic [7:0]                   text_buf [BUF_DEPTH];
        int unsigned                  wr_ptr;
        int unsigned                  rd_ptr;
        bit                           quote_on;
        bit                           str_open;
        bit                           trunc_on;
        bit [mqse_pkg::OUT_CNT_W-1:0] class_cnt [mqse_pkg::NUM_CNT];
        t_esc_result                  expected_results [$];
        int                           errors;

        function new();
            quot_set = '0;
            esc_set  = '0;
            wr_ptr   = 0;
            rd_ptr   = 0;
            quote_on = 0;
            str_open = 0;
            trunc_on = 0;
            errors   = 0;
            foreach (class_cnt[i]) class_cnt[i] = '0;
        endfunction

        function void set_reg(logic [mqse_pkg::CFG_IDX_W-1:0] idx,
                              logic [mqse_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                mqse_pkg::CFG_QUOT_LO: quot_set[63:0]   = v;
                mqse_pkg::CFG_QUOT_HI: quot_set[127:64] = v;
                mqse_pkg::CFG_INT_LO:  esc_set[63:0]    = v;
                mqse_pkg::CFG_INT_HI:  esc_set[127:64]  = v;
                default: ;
            endcase
        endfunction

        function bit needs_escape(logic [7:0] b);
            if (b == mqse_pkg::CH_NUL || b[7]) return 0;
            if (b == mqse_pkg::CH_DQUOTE || b == mqse_pkg::CH_BSLASH
                    || b == mqse_pkg::CH_CR || b == mqse_pkg::CH_LF) return 1;
            return esc_set[b[6:0]];
        endfunction

        function bit forces_quote(logic [7:0] b);
            if (b[7]) return 0;
            if (b <= mqse_pkg::CH_US || b == mqse_pkg::CH_DEL || b == mqse_pkg::CH_SPACE) begin
                return 1;
            end
            if (needs_escape(b)) return 1;
            return quot_set[b[6:0]];
        endfunction

        function void bump(int i);
            if (class_cnt[i] != '1) class_cnt[i]++;
        endfunction

        function int unsigned quoted_len();
            return wr_ptr + (quote_on ? 2 : 0);
        endfunction

        function t_esc_result snapshot(logic [1:0] k, logic [7:0] d, logic l);
            t_esc_result r;
            r.kind   = k;
            r.data   = d;
            r.last   = l;
            r.quoted = quote_on;
            r.length = mqse_pkg::OUT_LEN_W'(quoted_len());
            for (int i = 0; i < mqse_pkg::NUM_CNT; i++) r.cnt[i] = class_cnt[i];
            return r;
        endfunction

        function void add_expect(t_esc_result r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function int drain_left();
            if (str_open) return 0;
            return int'(quoted_len()) - int'(rd_ptr);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_input(logic kind, logic [7:0] b, logic last);
            bit          esc;
            int unsigned need;
            int unsigned len;
            int unsigned r;
            logic [7:0]  ch;
            if (kind == mqse_pkg::KIND_TEXT) begin
                if (!str_open) begin
                    str_open = 1;
                    wr_ptr   = 0;
                    rd_ptr   = 0;
                    quote_on = 0;
                    trunc_on = 0;
                end
                esc  = needs_escape(b);
                need = esc ? 2 : 1;
                if (wr_ptr + need <= BUF_DEPTH) begin
                    if (esc) begin
                        text_buf[wr_ptr] = mqse_pkg::CH_BSLASH;
                        wr_ptr++;
                    end
                    text_buf[wr_ptr] = b;
                    wr_ptr++;
                    if (forces_quote(b)) quote_on = 1;
                end else begin
                    trunc_on = 1;
                end
                if (b == mqse_pkg::CH_CR) bump(mqse_pkg::CNT_CR);
                else if (b == mqse_pkg::CH_LF) bump(mqse_pkg::CNT_NL);
                else if (b == mqse_pkg::CH_NUL) bump(mqse_pkg::CNT_NUL);
                else if (b <= mqse_pkg::CH_US || b == mqse_pkg::CH_DEL) bump(mqse_pkg::CNT_CTL);
                else if (b[7]) bump(mqse_pkg::CNT_EXT);
                else bump(mqse_pkg::CNT_OTHER);
                bump(mqse_pkg::CNT_TOTAL);
                if (last) begin
                    str_open = 0;
                    add_expect(snapshot(trunc_on ? mqse_pkg::OUT_SUM_TRUNC : mqse_pkg::OUT_SUM,
                                        8'h00, 1'b0));
                end
            end else begin
                len = quoted_len();
                r   = rd_ptr;
                if (str_open || r >= len) begin
                    add_expect(snapshot(mqse_pkg::OUT_NONE, 8'h00, 1'b0));
                end else begin
                    if (quote_on) begin
                        ch = (r == 0 || r == len - 1) ? mqse_pkg::CH_DQUOTE : text_buf[r - 1];
                    end else begin
                        ch = text_buf[r];
                    end
                    rd_ptr = r + 1;
                    add_expect(snapshot(mqse_pkg::OUT_TEXT, ch, r == len - 1));
                end
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_esc_result got);
            t_esc_result want;
            if (expected_results.size() == 0) begin
                report("unexpected result out_kind", 32'(got.kind), 32'(mqse_pkg::OUT_NONE));
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind) report("out_kind", 32'(got.kind), 32'(want.kind));
            if (got.data !== want.data) report("out_byte", 32'(got.data), 32'(want.data));
            if (got.last !== want.last) report("out_last", 32'(got.last), 32'(want.last));
            if (got.quoted !== want.quoted) report("quoted", 32'(got.quoted), 32'(want.quoted));
            if (got.length !== want.length) begin
                report("out_length", 32'(got.length), 32'(want.length));
            end
            for (int i = 0; i < mqse_pkg::NUM_CNT; i++) begin
                if (got.cnt[i] !== want.cnt[i]) begin
                    report($sformatf("class count %0d", i), got.cnt[i], want.cnt[i]);
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mqse_in_if  in_ch ();
    mqse_out_if out_ch ();
    mqse_cfg_if cfg_ch ();

    mail_quoted_string_escaper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_escaper_scoreboard sb = new();
    t_esc_result         seen_result;
    int                  items_sent = 0;
    int                  burst_left = 0;
    int                  idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 10);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(0, 12);
    endtask

    task automatic push_item(logic kind, logic [7:0] b, logic last);
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_input(kind, b, last);
        items_sent++;
        pace();
    endtask

    task automatic write_reg(logic [mqse_pkg::CFG_IDX_W-1:0] idx,
                             logic [mqse_pkg::CFG_DATA_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.set_reg(idx, v);
    endtask

    task automatic quiesce();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2:    return SPECIALS[$urandom_range(0, 9)];
            3, 4, 5, 6: return 8'($urandom_range(32, 126));
            default:    return 8'($urandom);
        endcase
    endfunction

    task automatic send_string(int n, bit noisy);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                push_item(mqse_pkg::KIND_DRAIN, 8'($urandom), 1'b0);
            end
            push_item(mqse_pkg::KIND_TEXT, pick_byte(), i == n - 1);
        end
    endtask

    task automatic drain_out(int n);
        repeat (n) push_item(mqse_pkg::KIND_DRAIN, 8'($urandom), 1'($urandom));
    endtask

    // fills the buffer to one short of full, then an escaped byte must drop whole
    task automatic send_overflow();
        if (sb.str_open) push_item(mqse_pkg::KIND_TEXT, "c", 1'b1);
        repeat (255) push_item(mqse_pkg::KIND_TEXT, mqse_pkg::CH_DQUOTE, 1'b0);
        push_item(mqse_pkg::KIND_TEXT, "a", 1'b0);
        push_item(mqse_pkg::KIND_TEXT, mqse_pkg::CH_DQUOTE, 1'b0);
        push_item(mqse_pkg::KIND_TEXT, "b", 1'b0);
        repeat (2) push_item(mqse_pkg::KIND_TEXT, 8'($urandom_range(128, 255)), 1'b0);
        push_item(mqse_pkg::KIND_TEXT, 8'($urandom_range(128, 255)), 1'b1);
        drain_out(sb.drain_left() + 1);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            seen_result.kind                      = out_ch.out_kind;
            seen_result.data                      = out_ch.out_byte;
            seen_result.last                      = out_ch.out_last;
            seen_result.quoted                    = out_ch.quoted;
            seen_result.length                    = out_ch.out_length;
            seen_result.cnt[mqse_pkg::CNT_CR]     = out_ch.cr_count;
            seen_result.cnt[mqse_pkg::CNT_NL]     = out_ch.nl_count;
            seen_result.cnt[mqse_pkg::CNT_NUL]    = out_ch.nul_count;
            seen_result.cnt[mqse_pkg::CNT_CTL]    = out_ch.ctl_count;
            seen_result.cnt[mqse_pkg::CNT_EXT]    = out_ch.ext_count;
            seen_result.cnt[mqse_pkg::CNT_OTHER]  = out_ch.other_count;
            seen_result.cnt[mqse_pkg::CNT_TOTAL]  = out_ch.total_count;
            sb.check_result(seen_result);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : rx_stall
        int mode;
        int mode_left;
        int hold;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= (mode_left % 3 == 0);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 20);
                    end
                end
            endcase
        end
    end

    initial begin : stimulus
        logic [mqse_pkg::CFG_DATA_W-1:0] q_lo, q_hi, e_lo, e_hi;
        int                              phase_start;
        int                              pick;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= mqse_pkg::KIND_TEXT;
        in_ch.in_byte  <= 8'h00;
        in_ch.in_last  <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= mqse_pkg::CFG_QUOT_LO;
        cfg_ch.data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // drain before any string, then every byte class with an early drain inside
        push_item(mqse_pkg::KIND_DRAIN, 8'h00, 1'b0);
        for (int i = 0; i < 10; i++) begin
            if (i == 3) push_item(mqse_pkg::KIND_DRAIN, 8'hff, 1'b1);
            push_item(mqse_pkg::KIND_TEXT, DIR_BYTES[i], i == 9);
        end
        drain_out(sb.drain_left() + 1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            quiesce();
            case (phase)
                0: begin
                    q_lo = '0; q_hi = '0; e_lo = '0; e_hi = '0;
                end
                1: begin
                    q_lo = '1; q_hi = '1; e_lo = '1; e_hi = '1;
                end
                2: begin
                    q_lo = {$urandom, $urandom}; q_hi = {$urandom, $urandom};
                    e_lo = {$urandom, $urandom}; e_hi = {$urandom, $urandom};
                end
                3: begin
                    q_lo = {$urandom, $urandom} & {$urandom, $urandom};
                    q_hi = {$urandom, $urandom} & {$urandom, $urandom};
                    e_lo = {$urandom, $urandom} & {$urandom, $urandom};
                    e_hi = {$urandom, $urandom} & {$urandom, $urandom};
                end
                4: begin
                    q_lo = '1; q_hi = '0; e_lo = '0; e_hi = '0;
                end
                default: begin
                    q_lo = '0; q_hi = '1;
                    e_lo = {$urandom, $urandom}; e_hi = {$urandom, $urandom};
                end
            endcase
            write_reg(mqse_pkg::CFG_QUOT_LO, q_lo);
            write_reg(mqse_pkg::CFG_QUOT_HI, q_hi);
            write_reg(mqse_pkg::CFG_INT_LO, e_lo);
            write_reg(mqse_pkg::CFG_INT_HI, e_hi);
            cfg_ch.valid <= 1'b0;
            @(posedge i_clk);

            if (phase == 4) send_overflow();
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    repeat ($urandom_range(1, 4)) begin
                        push_item(1'($urandom), 8'($urandom), 1'($urandom));
                    end
                end else if (pick < 12) begin
                    send_string($urandom_range(1, 12), 1'b0);
                    drain_out(sb.drain_left() / 2);
                end else if (pick < 15) begin
                    quiesce();
                end else begin
                    send_string(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                            : $urandom_range(1, 12),
                                $urandom_range(0, 7) == 0);
                    drain_out(sb.drain_left() + $urandom_range(0, 2));
                end
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("leftover expectations", sb.pending(), 0);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
